// ===== sv/rrtcp_pkg.sv =====
// Shared types and constants for the register ready-time scoreboard.
// No dependencies; imported by the top level.
`default_nettype none

package rrtcp_pkg;

   // width of ready times, cycle bound and counters
   localparam int TIME_W = 64;
   // width of the load-to-use latency register
   localparam int LAT_W = 8;
   // width of a register number in a trace record
   localparam int REG_W = 5;
   // width of the instruction word
   localparam int WORD_W = 32;

   // load latency after reset
   localparam logic [LAT_W-1:0] LAT_RESET = 8'd2;

   // major opcodes that mark a load (integer and floating point)
   localparam logic [6:0] OPC_LOAD    = 7'h03;
   localparam logic [6:0] OPC_LOAD_FP = 7'h07;

   // trace record command codes
   typedef enum logic [1:0] {
      CMD_INSTR = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_END   = 2'd2,
      CMD_TERM  = 2'd3
   } cmd_type;

   // true when the instruction word is a load
   function automatic logic is_load(input logic [WORD_W-1:0] word);
      logic [6:0] opc;
      opc = word[6:0];
      return (opc == OPC_LOAD) || (opc == OPC_LOAD_FP);
   endfunction

endpackage

`default_nettype wire

// ===== sv/rrtcp_ram.sv =====
// Generic RAM: one write port, two registered read ports (read returns old data).
// No dependencies.
`default_nettype none

module rrtcp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // storage write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ===== sv/register_ready_time_critical_path_top.sv =====
// Top level of the register ready-time scoreboard (dataflow limit estimate).
// Depends on rrtcp_pkg and rrtcp_ram.
//
// Usage:
//  - req channel (valid/ready) takes one trace record per item: a command and,
//    for instructions, destination, two sources and the instruction word.
//  - rsp channel (valid/ready) returns one item per record: instruction count,
//    load count, cycle bound as they stand after the record, and a finished
//    flag that is set for the terminate command.
//  - csr_wr_en/csr_wr_data set the load-to-use latency (reset value LAT_RESET); write
//    it only while no item is in flight.
// Timing:
//  - an accepted item passes the input register and then the result register
//    on its way to rsp; one item per cycle is sustained while rsp_ready is high.
//  - the ready-time table is a RAM with registered reads; sources are read as
//    the item enters the input register, and the write of the item ahead is
//    forwarded, so dependent items follow back to back.
// Reset: synchronous; clears counters, cycle bound, statistics enable and the
//  per-entry valid bits of the table at once (no clearing pass is needed).
// Stall: while rsp_ready is low the result is held, the input register keeps
//  its item and req_ready drops once that register is full.
`default_nettype none

module register_ready_time_critical_path_top
   import rrtcp_pkg::*;
#(
   parameter int REG_COUNT = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // trace record input
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic [REG_W-1:0]   req_dest_reg,
   input  wire logic [REG_W-1:0]   req_src_reg_a,
   input  wire logic [REG_W-1:0]   req_src_reg_b,
   input  wire logic [WORD_W-1:0]  req_instr_word,
   // result output
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [TIME_W-1:0]       rsp_instructions_counted,
   output logic [TIME_W-1:0]       rsp_loads_counted,
   output logic [TIME_W-1:0]       rsp_cycle_bound,
   output logic                    rsp_finished,
   // latency register write
   input  wire logic               csr_wr_en,
   input  wire logic [LAT_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int CMP_W = REG_W + 2;
   localparam logic [CMP_W-1:0] REG_LIMIT = CMP_W'(REG_COUNT);
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // input register
   logic               s1_valid_ff;
   cmd_type            s1_cmd_ff;
   logic [REG_W-1:0]   s1_dest_ff;
   logic [REG_W-1:0]   s1_src_a_ff;
   logic [REG_W-1:0]   s1_src_b_ff;
   logic [WORD_W-1:0]  s1_word_ff;

   // scoreboard state
   logic [REG_COUNT-1:0] entry_valid_ff, entry_valid_in;
   logic                 stats_en_ff, stats_en_in;
   logic [TIME_W-1:0]    cycle_total_ff, cycle_total_in;
   logic [TIME_W-1:0]    instr_total_ff, instr_total_in;
   logic [TIME_W-1:0]    load_total_ff, load_total_in;
   logic [LAT_W-1:0]     latency_ff;

   // result register
   logic rsp_valid_ff;
   logic rsp_finished_ff;

   // write forwarding register
   logic               fwd_valid_ff;
   logic [IDX_W-1:0]   fwd_addr_ff;
   logic [TIME_W-1:0]  fwd_data_ff;

   logic               fire;
   logic               req_accept;
   logic [IDX_W-1:0]   rd_addr_a, rd_addr_b;
   logic [TIME_W-1:0]  ram_data_a, ram_data_b;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   idx_a, idx_b;
   logic               in_range_a, in_range_b, in_range_d;
   logic [TIME_W-1:0]  time_a, time_b, time_max, lat_ext, new_time;
   logic [TIME_W:0]    sum_wide;
   logic               load_hit;

   // handshakes
   assign fire       = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || fire;
   assign req_accept = req_valid && req_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_accept) begin
         s1_cmd_ff   <= cmd_type'(req_command);
         s1_dest_ff  <= req_dest_reg;
         s1_src_a_ff <= req_src_reg_a;
         s1_src_b_ff <= req_src_reg_b;
         s1_word_ff  <= req_instr_word;
      end
   end

   // read the sources of whatever item sits in the input register next cycle
   assign rd_addr_a = req_accept ? IDX_W'(req_src_reg_a) : IDX_W'(s1_src_a_ff);
   assign rd_addr_b = req_accept ? IDX_W'(req_src_reg_b) : IDX_W'(s1_src_b_ff);

   rrtcp_ram #(
      .WIDTH (TIME_W),
      .DEPTH (REG_COUNT)
   ) u_ready_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (new_time),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_data_a),
      .rd_data_b (ram_data_b)
   );

   // source ready times: out of range or never written reads zero,
   // a write at the read edge is forwarded
   assign idx_a      = IDX_W'(s1_src_a_ff);
   assign idx_b      = IDX_W'(s1_src_b_ff);
   assign wr_addr    = IDX_W'(s1_dest_ff);
   assign in_range_a = {2'b00, s1_src_a_ff} < REG_LIMIT;
   assign in_range_b = {2'b00, s1_src_b_ff} < REG_LIMIT;
   assign in_range_d = {2'b00, s1_dest_ff} < REG_LIMIT;

   always_comb begin
      if (!in_range_a) begin
         time_a = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == idx_a)) begin
         time_a = fwd_data_ff;
      end else if (entry_valid_ff[idx_a]) begin
         time_a = ram_data_a;
      end else begin
         time_a = '0;
      end
      if (!in_range_b) begin
         time_b = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == idx_b)) begin
         time_b = fwd_data_ff;
      end else if (entry_valid_ff[idx_b]) begin
         time_b = ram_data_b;
      end else begin
         time_b = '0;
      end
   end

   // new ready time: later source plus an increment (the latency register for loads), saturating
   assign load_hit = is_load(s1_word_ff);
   assign time_max = (time_a > time_b) ? time_a : time_b;
   assign lat_ext  = load_hit ? TIME_W'(latency_ff) : TIME_W'(1);
   assign sum_wide = {1'b0, time_max} + {1'b0, lat_ext};
   assign new_time = sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];

   // state update for the item in the input register
   always_comb begin
      stats_en_in    = stats_en_ff;
      cycle_total_in = cycle_total_ff;
      instr_total_in = instr_total_ff;
      load_total_in  = load_total_ff;
      entry_valid_in = entry_valid_ff;
      wr_en          = 1'b0;
      if (fire) begin
         case (s1_cmd_ff)
            CMD_BEGIN: begin
               stats_en_in = 1'b1;
            end
            CMD_END: begin
               stats_en_in = 1'b0;
            end
            CMD_INSTR: begin
               if (stats_en_ff) begin
                  if (instr_total_ff != TIME_MAX) begin
                     instr_total_in = instr_total_ff + TIME_W'(1);
                  end
                  if (s1_dest_ff != '0) begin
                     if (in_range_d) begin
                        wr_en                   = 1'b1;
                        entry_valid_in[wr_addr] = 1'b1;
                     end
                     if (new_time > cycle_total_ff) begin
                        cycle_total_in = new_time;
                     end
                     if (load_hit && (load_total_ff != TIME_MAX)) begin
                        load_total_in = load_total_ff + TIME_W'(1);
                     end
                  end
               end
            end
            default: begin
               // terminate leaves the state alone
            end
         endcase
      end
   end

   // state, forwarding and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         stats_en_ff    <= 1'b0;
         cycle_total_ff <= '0;
         instr_total_ff <= '0;
         load_total_ff  <= '0;
         latency_ff     <= LAT_RESET;
         fwd_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         stats_en_ff    <= stats_en_in;
         cycle_total_ff <= cycle_total_in;
         instr_total_ff <= instr_total_in;
         load_total_ff  <= load_total_in;
         if (csr_wr_en) begin
            latency_ff <= csr_wr_data;
         end
         fwd_valid_ff <= wr_en;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= new_time;
      if (fire) begin
         rsp_finished_ff <= (s1_cmd_ff == CMD_TERM);
      end
   end

   // totals only move when a result is loaded, so they drive rsp directly
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_instructions_counted = instr_total_ff;
   assign rsp_loads_counted        = load_total_ff;
   assign rsp_cycle_bound          = cycle_total_ff;
   assign rsp_finished             = rsp_finished_ff;

   // every counted load is also a counted instruction
   a_loads_le_instr: assert property (@(posedge clock) disable iff (reset)
      load_total_ff <= instr_total_ff)
      else $error("load count exceeds instruction count");

   // the cycle bound never decreases
   a_bound_monotone: assert property (@(posedge clock) disable iff (reset)
      fire |=> cycle_total_ff >= $past(cycle_total_ff))
      else $error("cycle bound decreased");

   // terminate leaves every total unchanged
   a_term_no_change: assert property (@(posedge clock) disable iff (reset)
      (fire && (s1_cmd_ff == CMD_TERM)) |=>
         ($stable(cycle_total_ff) && $stable(instr_total_ff) && $stable(load_total_ff)))
      else $error("terminate changed a total");

   // a table write only happens with statistics on and a result being loaded
   a_write_gated: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (fire && stats_en_ff && (s1_dest_ff != '0)))
      else $error("ready-time write outside an instruction");

endmodule

`default_nettype wire
